// ===== rtl/wsdf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsdf_pkg
// Types and constants shared by the frame deframer.
// ----------------------------------------------------------------------------
package wsdf_pkg;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4,
    PH_DOWN = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_TOO_BIG = 2'd1,
    ERR_INVALID = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    KIND_TEXT   = 3'd0,
    KIND_BINARY = 3'd1,
    KIND_PING   = 3'd2,
    KIND_PONG   = 3'd3,
    KIND_CLOSE  = 3'd4,
    KIND_OTHER  = 3'd5
  } kind_t;

  localparam logic [3:0]  OP_CONT   = 4'h0;
  localparam logic [3:0]  OP_TEXT   = 4'h1;
  localparam logic [3:0]  OP_BINARY = 4'h2;
  localparam logic [3:0]  OP_CLOSE  = 4'h8;
  localparam logic [3:0]  OP_PING   = 4'h9;
  localparam logic [3:0]  OP_PONG   = 4'hA;

  localparam logic [6:0]  LEN7_EXT16 = 7'd126;
  localparam logic [6:0]  LEN7_EXT64 = 7'd127;
  localparam logic [3:0]  EXT16_BYTES = 4'd2;
  localparam logic [3:0]  EXT64_BYTES = 4'd8;
  localparam logic [31:0] CTRL_MAX_LEN = 32'd125;
  localparam logic [31:0] MAX_LEN_RESET = 32'd65536;

  function automatic kind_t kind_of(input logic [3:0] op);
    kind_t k;
    case (op)
      OP_TEXT:   k = KIND_TEXT;
      OP_BINARY: k = KIND_BINARY;
      OP_PING:   k = KIND_PING;
      OP_PONG:   k = KIND_PONG;
      OP_CLOSE:  k = KIND_CLOSE;
      default:   k = KIND_OTHER;
    endcase
    return k;
  endfunction

  function automatic logic op_known(input logic [3:0] op);
    return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BINARY) ||
           (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
  endfunction

endpackage

// ===== rtl/websocket_frame_deframer.sv =====
`timescale 1ns / 1ps
// A result enters the output register in the cycle after its word is taken.
// Throughput: one word per cycle while the output is not stalled; a single pass
// of header/length/unmask logic between the parse state and the output register.
// Reset (rst, synchronous): parser waits for a first header byte,
// max_len = 65536, output register empty.
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses the incoming frame stream byte by byte and emits unmasked payload
// bytes, empty-frame markers and error results.
// ----------------------------------------------------------------------------
module websocket_frame_deframer
  import wsdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] max_payload_len,

  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,

  output logic        res_valid,
  input  logic        res_stall,
  output logic [7:0]  out_byte,
  output logic        carries_byte,
  output logic [2:0]  frame_kind,
  output logic        frame_end,
  output logic        final_fragment,
  output logic [1:0]  error_code,
  output logic        link_up
);

  logic [31:0] max_len;

  phase_t      phase, phase_next;
  logic        hdr_final, hdr_final_next;
  logic [3:0]  hdr_opcode, hdr_opcode_next;
  logic        hdr_masked, hdr_masked_next;
  logic [3:0]  ext_left, ext_left_next;
  logic [31:0] rem_len, rem_len_next;
  logic        len_hi, len_hi_next;
  logic [31:0] key_word, key_word_next;
  logic [1:0]  key_phase, key_phase_next;

  logic        accept;
  logic [31:0] cand_len;
  logic        cand_hi;
  logic        masked_eff;
  logic        len_done, too_big, key_done, hdr_done, invalid, empty;
  logic        data_last;
  logic [7:0]  key_byte;

  logic        r_any;
  logic [7:0]  r_byte;
  logic        r_carries, r_end, r_up;
  err_t        r_err;

  assign cfg_ready = 1'b1;
  assign rx_stall  = res_valid & res_stall;
  assign accept    = rx_valid & ~rx_stall;

  // length / header decode
  always_comb begin
    case (phase)
      PH_HDR1: cand_len = {25'd0, rx_byte[6:0]};
      PH_EXT:  cand_len = {rem_len[23:0], rx_byte};
      default: cand_len = rem_len;
    endcase
    cand_hi    = (phase == PH_EXT) ? (len_hi | (rem_len[31:24] != 8'd0)) : len_hi;
    masked_eff = (phase == PH_HDR1) ? rx_byte[7] : hdr_masked;
    len_done   = ((phase == PH_HDR1) && (rx_byte[6:0] != LEN7_EXT16) &&
                  (rx_byte[6:0] != LEN7_EXT64)) ||
                 ((phase == PH_EXT) && (ext_left == 4'd1));
    too_big    = cand_hi || (cand_len > max_len);
    key_done   = (phase == PH_KEY) && (key_phase == 2'd3);
    hdr_done   = (len_done && !too_big && !masked_eff) || key_done;
    invalid    = !op_known(hdr_opcode) ||
                 (hdr_opcode[3] && (!hdr_final || (cand_len > CTRL_MAX_LEN)));
    empty      = (cand_len == 32'd0);
    data_last  = (rem_len == 32'd1);
    key_byte   = key_word[8*(3-key_phase) +: 8];
  end

  // next state
  always_comb begin
    phase_next      = phase;
    hdr_final_next  = hdr_final;
    hdr_opcode_next = hdr_opcode;
    hdr_masked_next = hdr_masked;
    ext_left_next   = ext_left;
    rem_len_next    = rem_len;
    len_hi_next     = len_hi;
    key_word_next   = key_word;
    key_phase_next  = key_phase;
    case (phase)
      PH_HDR0: begin
        hdr_final_next  = rx_byte[7];
        hdr_opcode_next = rx_byte[3:0];
        key_word_next   = 32'd0;
        key_phase_next  = 2'd0;
        phase_next      = PH_HDR1;
      end
      PH_HDR1: begin
        hdr_masked_next = rx_byte[7];
        len_hi_next     = 1'b0;
        rem_len_next    = cand_len;
        if (rx_byte[6:0] == LEN7_EXT16) begin
          rem_len_next  = 32'd0;
          ext_left_next = EXT16_BYTES;
          phase_next    = PH_EXT;
        end else if (rx_byte[6:0] == LEN7_EXT64) begin
          rem_len_next  = 32'd0;
          ext_left_next = EXT64_BYTES;
          phase_next    = PH_EXT;
        end
      end
      PH_EXT: begin
        rem_len_next  = cand_len;
        len_hi_next   = cand_hi;
        ext_left_next = ext_left - 4'd1;
      end
      PH_KEY: begin
        key_word_next  = {key_word[23:0], rx_byte};
        key_phase_next = key_phase + 2'd1;
      end
      PH_DATA: begin
        key_phase_next = key_phase + 2'd1;
        rem_len_next   = rem_len - 32'd1;
        if (data_last) begin
          phase_next = (hdr_opcode == OP_CLOSE) ? PH_DOWN : PH_HDR0;
        end
      end
      PH_DOWN: begin
        phase_next = PH_DOWN;
      end
      default: begin
        phase_next = PH_DOWN;
      end
    endcase

    if (len_done) begin
      if (too_big) begin
        phase_next = PH_DOWN;
      end else if (masked_eff) begin
        key_phase_next = 2'd0;
        phase_next     = PH_KEY;
      end
    end
    if (hdr_done) begin
      key_phase_next = 2'd0;
      if (invalid) begin
        phase_next = PH_DOWN;
      end else if (empty) begin
        phase_next = (hdr_opcode == OP_CLOSE) ? PH_DOWN : PH_HDR0;
      end else begin
        phase_next = PH_DATA;
      end
    end
  end

  // result
  always_comb begin
    r_any     = 1'b0;
    r_byte    = 8'd0;
    r_carries = 1'b0;
    r_end     = 1'b1;
    r_err     = ERR_NONE;
    r_up      = 1'b1;
    if (len_done && too_big) begin
      r_any = 1'b1;
      r_err = ERR_TOO_BIG;
      r_up  = 1'b0;
    end else if (hdr_done && invalid) begin
      r_any = 1'b1;
      r_err = ERR_INVALID;
      r_up  = 1'b0;
    end else if (hdr_done && empty) begin
      r_any = 1'b1;
      r_up  = (hdr_opcode != OP_CLOSE);
    end else if (phase == PH_DATA) begin
      r_any     = 1'b1;
      r_byte    = rx_byte ^ key_byte;
      r_carries = 1'b1;
      r_end     = data_last;
      r_up      = !(data_last && (hdr_opcode == OP_CLOSE));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len <= max_payload_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HDR0;
      hdr_final  <= 1'b0;
      hdr_opcode <= 4'd0;
      hdr_masked <= 1'b0;
      ext_left   <= 4'd0;
      rem_len    <= 32'd0;
      len_hi     <= 1'b0;
      key_word   <= 32'd0;
      key_phase  <= 2'd0;
    end else if (accept) begin
      phase      <= phase_next;
      hdr_final  <= hdr_final_next;
      hdr_opcode <= hdr_opcode_next;
      hdr_masked <= hdr_masked_next;
      ext_left   <= ext_left_next;
      rem_len    <= rem_len_next;
      len_hi     <= len_hi_next;
      key_word   <= key_word_next;
      key_phase  <= key_phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && r_any) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && r_any) begin
      out_byte       <= r_byte;
      carries_byte   <= r_carries;
      frame_kind     <= kind_of(hdr_opcode);
      frame_end      <= r_end;
      final_fragment <= hdr_final;
      error_code     <= r_err;
      link_up        <= r_up;
    end
  end

`ifndef SYNTHESIS
  a_err_drops_link: assert property (@(posedge clk) disable iff (rst)
    res_valid && (error_code != ERR_NONE) |-> !link_up && frame_end && !carries_byte)
    else $error("error result without link drop");

  a_down_on_link_loss: assert property (@(posedge clk) disable iff (rst)
    res_valid && !link_up |-> phase == PH_DOWN)
    else $error("link reported down while parser still running");

  a_down_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DOWN |=> phase == PH_DOWN)
    else $error("parser left the down state");

  a_byte_no_error: assert property (@(posedge clk) disable iff (rst)
    res_valid && carries_byte |-> error_code == ERR_NONE)
    else $error("payload word tagged with an error");
`endif

endmodule
